// ===== src/cmst_pkg.sv =====
// Shared types, constants and helper functions for the CAN message slot table.
// Used by every module of the block but cmst_ram; depends on nothing else.
package cmst_pkg;

  // Request codes of the input item.
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_SET  = 2'd1;
  localparam logic [1:0] REQ_RECV = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  // Slot modes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TX   = 2'd1;
  localparam logic [1:0] MODE_RX   = 2'd2;

  // Result kinds.
  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_AGE_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_AGE_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_STALE_MARGIN = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] AGE_INTERVAL_RST = 16'd1000;
  localparam logic [3:0]  AGE_LIMIT_RST    = 4'd5;
  localparam logic [15:0] STALE_MARGIN_RST = 16'd2000;

  // Fixed sizes.
  localparam int ID_SPACE = 2048;
  localparam int MAX_RES  = 32;
  localparam logic [3:0] FULL_LEN = 4'd8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [10:0] frame_id;
    logic        is_extended;
    logic        is_remote;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [15:0] cycle_ms;
    logic        transmit_enable;
    logic [4:0]  slot_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [10:0] out_id;
    logic        out_id_valid;
    logic [3:0]  out_dlc;
    logic [63:0] out_payload;
    logic [15:0] out_cycle_ms;
    logic [1:0]  out_mode;
    logic [31:0] change_ages;
    logic [31:0] recv_ages;
    logic        last;
  } res_item_t;

  // Operation classes handed from the front end to the engine.
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_SET      = 3'd1,
    OP_RECV     = 3'd2,
    OP_READ     = 3'd3,
    OP_BAD_READ = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [10:0] frame_id;
    logic [3:0]  len;
    logic [63:0] payload;
    logic [15:0] cycle_ms;
    logic        tx_en;
    logic [4:0]  slot_index;
  } op_t;

  typedef struct packed {
    logic [15:0] age_interval;
    logic [3:0]  age_limit;
    logic [15:0] stale_margin;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } eng_stat_t;

  // One slot of the table.
  typedef struct packed {
    logic        ident_ok;
    logic [10:0] ident;
    logic [3:0]  length;
    logic [1:0]  mode;
    logic [15:0] period;
    logic [63:0] bytes;
    logic [31:0] last_event;
    logic [31:0] last_set;
    logic [31:0] change_ages;
    logic [31:0] recv_ages;
  } slot_rec_t;

  localparam slot_rec_t SLOT_REC_RESET = '{
    ident_ok: 1'b0, ident: 11'd0, length: 4'd1, mode: MODE_IDLE,
    period: 16'd1500, bytes: 64'd0, last_event: 32'd0, last_set: 32'd0,
    change_ages: 32'd0, recv_ages: 32'd0
  };

  // Byte mask covering the first len bytes.
  function automatic logic [63:0] len_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < len) m[k*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

  // Age the first len nibbles by one, holding at the limit.
  function automatic logic [31:0] grow_ages(input logic [31:0] ages,
                                            input logic [3:0] len,
                                            input logic [3:0] limit);
    logic [31:0] a;
    a = ages;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < len && ages[k*4 +: 4] < limit) a[k*4 +: 4] = ages[k*4 +: 4] + 4'd1;
    end
    return a;
  endfunction

  // Build a result from a slot record.
  function automatic res_item_t make_item(input logic kind, input slot_rec_t rec,
                                          input logic with_ages);
    res_item_t r;
    r.result_kind  = kind;
    r.out_id       = rec.ident_ok ? rec.ident : 11'd0;
    r.out_id_valid = rec.ident_ok;
    r.out_dlc      = rec.length;
    r.out_payload  = rec.bytes;
    r.out_cycle_ms = rec.period;
    r.out_mode     = rec.mode;
    r.change_ages  = with_ages ? rec.change_ages : 32'd0;
    r.recv_ages    = with_ages ? rec.recv_ages : 32'd0;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

// ===== src/can_message_slot_table_core.sv =====
// Top level of the CAN message slot table: configuration registers, front end,
// operation queue and engine. Depends on cmst_pkg and all cmst_* modules.
//
// Usage:
//   Commands enter on in_data and transfer when start is high and busy is low.
//   A tick advances the millisecond clock and scans every slot, emitting each
//   due transmit slot; set and receive store into the slot of the frame's
//   identifier; a read returns one slot. Results appear on out_data for a
//   single cycle with out_valid high, and the receiver always takes them; the
//   final result of a command carries last.
//   A read passes through S_READ, set and receive through S_MAP and S_SLOT,
//   and a tick scans one slot a cycle through the slot table's single read
//   port, with its last frame out at the end.
//   A two-entry queue lets up to two commands transfer while the engine works;
//   busy rises when it is full.
//   After reset all 2048 entries of the identifier map are swept clear, one
//   entry a cycle, with busy high. Configuration writes are always taken on the
//   cfg_ channel (cfg_ready stays high) and must only be made while idle.
module can_message_slot_table_core #(
  parameter int SLOTS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  cmst_pkg::in_item_t   in_data,
  output logic                 busy,
  output logic                 out_valid,
  output cmst_pkg::res_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  cmst_pkg::cfg_t       cfg_r, cfg_nxt;
  cmst_pkg::eng_stat_t  stat;
  cmst_pkg::op_t        push_op;
  cmst_pkg::op_t        head;
  logic                 push;
  logic                 pop;
  logic                 q_empty;
  logic                 q_full;

  assign cfg_ready = 1'b1;

  // Configuration register writes; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cmst_pkg::CFG_AGE_INTERVAL: cfg_nxt.age_interval = cfg_data;
        cmst_pkg::CFG_AGE_LIMIT:    cfg_nxt.age_limit    = cfg_data[3:0];
        cmst_pkg::CFG_STALE_MARGIN: cfg_nxt.stale_margin = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.age_interval <= cmst_pkg::AGE_INTERVAL_RST;
      cfg_r.age_limit    <= cmst_pkg::AGE_LIMIT_RST;
      cfg_r.stale_margin <= cmst_pkg::STALE_MARGIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cmst_front #(.SLOTS(SLOTS)) u_front (
    .start   (start),
    .in_data (in_data),
    .q_full  (q_full),
    .stat    (stat),
    .busy    (busy),
    .push    (push),
    .op      (push_op)
  );

  cmst_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .empty   (q_empty),
    .full    (q_full),
    .head    (head)
  );

  cmst_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

  // The map sweep runs once after reset and never restarts.
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.clearing |=> !stat.clearing)
    else $error("identifier map sweep restarted");

  // No result may appear while the map is being swept.
  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !out_valid)
    else $error("result during map sweep");

  // A read-back is always the only, hence last, result of its command.
  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == cmst_pkg::KIND_READ |-> out_data.last)
    else $error("read-back without last");

  // Transmit frames come from transmit slots and carry no ages.
  a_tx_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == cmst_pkg::KIND_TX |->
      out_data.out_mode == cmst_pkg::MODE_TX && out_data.change_ages == 32'd0 &&
      out_data.recv_ages == 32'd0)
    else $error("malformed transmit frame");

endmodule

// ===== src/cmst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Self-contained; used for the identifier map and the slot table.
module cmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== src/cmst_front.sv =====
// Front end: accepts command items and classifies them into engine operations.
// Depends on cmst_pkg.
module cmst_front #(
  parameter int SLOTS = 32
) (
  input  logic                 start,
  input  cmst_pkg::in_item_t   in_data,
  input  logic                 q_full,
  input  cmst_pkg::eng_stat_t  stat,
  output logic                 busy,
  output logic                 push,
  output cmst_pkg::op_t        op
);

  logic accept;
  logic drop;

  // Items are held off while the queue is full or the map is being cleared.
  assign busy   = q_full | stat.clearing;
  assign accept = start & ~busy;

  // Classify the request and clamp the length.
  always_comb begin
    op.frame_id   = in_data.frame_id;
    op.len        = (in_data.dlc > cmst_pkg::FULL_LEN) ? cmst_pkg::FULL_LEN : in_data.dlc;
    op.payload    = in_data.payload;
    op.cycle_ms   = in_data.cycle_ms;
    op.tx_en      = in_data.transmit_enable;
    op.slot_index = in_data.slot_index;
    drop          = 1'b0;
    case (in_data.req_type)
      cmst_pkg::REQ_TICK: op.kind = cmst_pkg::OP_TICK;
      cmst_pkg::REQ_SET:  op.kind = cmst_pkg::OP_SET;
      cmst_pkg::REQ_RECV: begin
        op.kind = cmst_pkg::OP_RECV;
        drop    = in_data.is_extended | in_data.is_remote;
      end
      cmst_pkg::REQ_READ: begin
        op.kind = (32'(in_data.slot_index) >= SLOTS) ? cmst_pkg::OP_BAD_READ
                                                     : cmst_pkg::OP_READ;
      end
      default: op.kind = cmst_pkg::OP_TICK;
    endcase
  end

  // Extended and remote receive requests are consumed without reaching the engine.
  assign push = accept & ~drop;

endmodule

// ===== src/cmst_queue.sv =====
// Two-entry operation queue between the front end and the engine.
// Depends on cmst_pkg.
module cmst_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cmst_pkg::op_t  push_op,
  input  logic           pop,
  output logic           empty,
  output logic           full,
  output cmst_pkg::op_t  head
);

  cmst_pkg::op_t q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = q_r[rptr_r];

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) q_r[wptr_r] <= push_op;
  end

endmodule

// ===== src/cmst_back.sv =====
// Engine: carries out queued operations on the identifier map and slot table.
// Depends on cmst_pkg and cmst_ram.
module cmst_back #(
  parameter int SLOTS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmst_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  cmst_pkg::op_t        q_head,
  output logic                 pop,
  output logic                 out_valid,
  output cmst_pkg::res_item_t  out_data,
  output cmst_pkg::eng_stat_t  stat
);

  localparam int SW = $clog2(SLOTS);
  localparam int IW = $clog2(cmst_pkg::ID_SPACE);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MAP   = 7'b0000100,
    S_SLOT  = 7'b0001000,
    S_READ  = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [IW-1:0]        clr_cnt_r, clr_cnt_nxt;
  cmst_pkg::op_t        op_r, op_nxt;
  logic [31:0]          now_r, now_nxt;
  logic [31:0]          last_age_r, last_age_nxt;
  logic                 age_go_r, age_go_nxt;
  logic [SW-1:0]        next_free_r, next_free_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;
  logic [SLOTS-1:0]     vld_r, vld_nxt;
  logic [5:0]           n_r, n_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  cmst_pkg::res_item_t  pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  cmst_pkg::res_item_t  out_r, out_nxt;

  logic                 map_we;
  logic [IW-1:0]        map_waddr;
  logic [SW:0]          map_wdata;
  logic [IW-1:0]        map_raddr;
  logic [SW:0]          map_rdata;
  logic                 slot_we;
  logic [SW-1:0]        slot_raddr;
  cmst_pkg::slot_rec_t  slot_wdata;
  cmst_pkg::slot_rec_t  slot_rdata;
  cmst_pkg::slot_rec_t  rec;

  logic [31:0]          now_inc;
  logic [31:0]          el;
  logic [63:0]          bmask;
  cmst_pkg::res_item_t  item;

  // Identifier map: valid flag over slot number, cleared by a sweep after reset.
  cmst_ram #(.WIDTH(SW + 1), .DEPTH(cmst_pkg::ID_SPACE)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Slot table; an entry never written reads as the reset record.
  cmst_ram #(.WIDTH($bits(cmst_pkg::slot_rec_t)), .DEPTH(SLOTS)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_r),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  assign rec = vld_r[slot_r] ? slot_rdata : cmst_pkg::SLOT_REC_RESET;

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign stat.clearing  = (state_r == S_CLEAR);
  assign now_inc        = now_r + 32'd1;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    op_nxt        = op_r;
    now_nxt       = now_r;
    last_age_nxt  = last_age_r;
    age_go_nxt    = age_go_r;
    next_free_nxt = next_free_r;
    slot_nxt      = slot_r;
    vld_nxt       = vld_r;
    n_nxt         = n_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pop           = 1'b0;
    map_we        = 1'b0;
    map_waddr     = op_r.frame_id;
    map_wdata     = '0;
    map_raddr     = q_head.frame_id;
    slot_we       = 1'b0;
    slot_raddr    = slot_r;
    slot_wdata    = rec;
    el            = now_r - rec.last_event;
    bmask         = cmst_pkg::len_mask(op_r.len);
    item          = cmst_pkg::make_item(cmst_pkg::KIND_TX, rec, 1'b0);

    case (state_r)
      // Sweep the identifier map to unassigned, one entry a cycle.
      S_CLEAR: begin
        map_we      = 1'b1;
        map_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IW'(cmst_pkg::ID_SPACE - 1)) state_nxt = S_IDLE;
      end

      // Take the next operation and issue its first memory read, or answer an out-of-range read.
      S_IDLE: begin
        if (!q_empty) begin
          pop    = 1'b1;
          op_nxt = q_head;
          case (q_head.kind)
            cmst_pkg::OP_TICK: begin
              now_nxt      = now_inc;
              age_go_nxt   = (now_inc - last_age_r) > {16'd0, cfg.age_interval};
              if ((now_inc - last_age_r) > {16'd0, cfg.age_interval}) begin
                last_age_nxt = now_inc;
              end
              slot_raddr   = '0;
              slot_nxt     = '0;
              n_nxt        = '0;
              pend_vld_nxt = 1'b0;
              state_nxt    = S_SCAN;
            end
            cmst_pkg::OP_SET, cmst_pkg::OP_RECV: begin
              state_nxt = S_MAP;
            end
            cmst_pkg::OP_READ: begin
              slot_raddr = SW'(q_head.slot_index);
              slot_nxt   = SW'(q_head.slot_index);
              state_nxt  = S_READ;
            end
            cmst_pkg::OP_BAD_READ: begin
              out_valid_nxt       = 1'b1;
              out_nxt             = '0;
              out_nxt.result_kind = cmst_pkg::KIND_READ;
              out_nxt.last        = 1'b1;
            end
            default: ;
          endcase
        end
      end

      // Resolve the slot, assigning the next free one on first use.
      S_MAP: begin
        if (!map_rdata[SW]) begin
          map_we     = 1'b1;
          map_wdata  = {1'b1, next_free_r};
          slot_raddr = next_free_r;
          slot_nxt   = next_free_r;
          if (next_free_r != SW'(SLOTS - 1)) next_free_nxt = next_free_r + 1'b1;
        end else begin
          slot_raddr = map_rdata[SW-1:0];
          slot_nxt   = map_rdata[SW-1:0];
        end
        state_nxt = S_SLOT;
      end

      // Update the slot for a transmit set or a received frame.
      S_SLOT: begin
        slot_we = 1'b1;
        if (op_r.kind == cmst_pkg::OP_SET) begin
          slot_wdata.ident    = op_r.frame_id;
          slot_wdata.ident_ok = 1'b1;
          slot_wdata.length   = op_r.len;
          slot_wdata.period   = op_r.cycle_ms;
          slot_wdata.bytes    = (rec.bytes & ~bmask) | (op_r.payload & bmask);
          slot_wdata.mode     = op_r.tx_en ? cmst_pkg::MODE_TX : cmst_pkg::MODE_IDLE;
          slot_wdata.last_set = now_r;
        end else begin
          slot_wdata.length     = op_r.len;
          slot_wdata.period     = (el[31:16] != 16'd0) ? 16'hFFFF : el[15:0];
          slot_wdata.last_event = now_r;
          slot_wdata.mode       = cmst_pkg::MODE_RX;
          slot_wdata.bytes      = (rec.bytes & ~bmask) | (op_r.payload & bmask);
          for (int k = 0; k < 8; k++) begin
            if (4'(k) < op_r.len) begin
              if (rec.bytes[k*8 +: 8] != op_r.payload[k*8 +: 8]) begin
                slot_wdata.change_ages[k*4 +: 4] = 4'd0;
              end
              slot_wdata.recv_ages[k*4 +: 4] = 4'd0;
            end
          end
        end
        state_nxt = S_IDLE;
      end

      // Return the slot and clear its receive mark.
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_nxt       = cmst_pkg::make_item(cmst_pkg::KIND_READ, rec, 1'b1);
        out_nxt.last  = 1'b1;
        if (rec.mode == cmst_pkg::MODE_RX) begin
          slot_we         = 1'b1;
          slot_wdata.mode = cmst_pkg::MODE_IDLE;
        end
        state_nxt = S_IDLE;
      end

      // Tick scan: one slot a cycle, reading the next while writing this one.
      S_SCAN: begin
        if (rec.mode == cmst_pkg::MODE_TX) begin
          if ((now_r - rec.last_set) >=
              (32'(rec.period) + 32'(cfg.stale_margin))) begin
            slot_we         = 1'b1;
            slot_wdata.mode = cmst_pkg::MODE_IDLE;
          end else if ((now_r - rec.last_event) >= 32'(rec.period) &&
                       n_r < 6'(cmst_pkg::MAX_RES)) begin
            slot_we               = 1'b1;
            slot_wdata.last_event = now_r;
            n_nxt                 = n_r + 6'd1;
            // Hold each frame back one step so the final one can be marked.
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
            end
            pend_nxt     = item;
            pend_vld_nxt = 1'b1;
          end
        end
        if (rec.mode == cmst_pkg::MODE_RX && age_go_r) begin
          slot_we                = 1'b1;
          slot_wdata.change_ages = cmst_pkg::grow_ages(rec.change_ages, rec.length,
                                                       cfg.age_limit);
          slot_wdata.recv_ages   = cmst_pkg::grow_ages(rec.recv_ages, rec.length,
                                                       cfg.age_limit);
        end
        if (slot_r == SW'(SLOTS - 1)) begin
          state_nxt = S_FLUSH;
        end else begin
          slot_raddr = slot_r + 1'b1;
          slot_nxt   = slot_r + 1'b1;
        end
      end

      // Release the held frame as the last of the tick.
      S_FLUSH: begin
        if (pend_vld_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    if (slot_we) vld_nxt[slot_r] = 1'b1;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      now_r       <= '0;
      last_age_r  <= '0;
      age_go_r    <= 1'b0;
      next_free_r <= '0;
      slot_r      <= '0;
      vld_r       <= '0;
      n_r         <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      now_r       <= now_nxt;
      last_age_r  <= last_age_nxt;
      age_go_r    <= age_go_nxt;
      next_free_r <= next_free_nxt;
      slot_r      <= slot_nxt;
      vld_r       <= vld_nxt;
      n_r         <= n_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== test/tb_can_message_slot_table_core.sv =====
// Self-checking testbench for can_message_slot_table_core: a directed table of commands
// and then random phases under several register settings, checked by a slot table model.
// Depends on cmst_pkg and the RTL of the block.
module tb_can_message_slot_table_core;

  localparam int NSLOT = 32;
  localparam int WATCH_LIMIT = 20000;
  localparam int SETTLE = 150;

  logic clk;
  logic rst_n;
  logic start;
  cmst_pkg::in_item_t in_data;
  logic busy;
  logic out_valid;
  cmst_pkg::res_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  can_message_slot_table_core #(.SLOTS(NSLOT)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .busy(busy),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model state of the slot table.
  logic [15:0] m_interval;
  logic [3:0]  m_limit;
  logic [15:0] m_margin;
  logic        id_known [cmst_pkg::ID_SPACE];
  logic [4:0]  id_slot [cmst_pkg::ID_SPACE];
  logic [4:0]  free_slot;
  logic [31:0] now_ms;
  logic [31:0] age_stamp;
  cmst_pkg::slot_rec_t slots [NSLOT];

  cmst_pkg::res_item_t pending_frames[$];
  cmst_pkg::res_item_t fresh[$];
  int errors;
  int quiet_cycles;
  int sender_idle_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic cmst_pkg::res_item_t slot_view(input logic kind, input int s,
                                                    input logic ages);
    cmst_pkg::res_item_t r;
    r.result_kind  = kind;
    r.out_id       = slots[s].ident_ok ? slots[s].ident : 11'd0;
    r.out_id_valid = slots[s].ident_ok;
    r.out_dlc      = slots[s].length;
    r.out_payload  = slots[s].bytes;
    r.out_cycle_ms = slots[s].period;
    r.out_mode     = slots[s].mode;
    r.change_ages  = ages ? slots[s].change_ages : 32'd0;
    r.recv_ages    = ages ? slots[s].recv_ages : 32'd0;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] age_up(input logic [31:0] a, input logic [3:0] len);
    logic [31:0] r;
    r = a;
    for (int k = 0; k < 8; k++)
      if (k < len && a[k*4 +: 4] < m_limit) r[k*4 +: 4] = a[k*4 +: 4] + 4'd1;
    return r;
  endfunction

  function automatic int slot_of(input logic [10:0] fid);
    if (!id_known[fid]) begin
      id_known[fid] = 1'b1;
      id_slot[fid] = free_slot;
      if (free_slot != 5'(NSLOT - 1)) free_slot = free_slot + 5'd1;
    end
    return id_slot[fid];
  endfunction

  task automatic model_reset();
    m_interval = cmst_pkg::AGE_INTERVAL_RST;
    m_limit = cmst_pkg::AGE_LIMIT_RST;
    m_margin = cmst_pkg::STALE_MARGIN_RST;
    for (int i = 0; i < cmst_pkg::ID_SPACE; i++) begin
      id_known[i] = 1'b0;
      id_slot[i] = '0;
    end
    free_slot = '0;
    now_ms = '0;
    age_stamp = '0;
    for (int i = 0; i < NSLOT; i++) slots[i] = cmst_pkg::SLOT_REC_RESET;
  endtask

  // Apply one command to the model; the results it causes land in fresh.
  task automatic table_step(input cmst_pkg::in_item_t it);
    int n;
    int s;
    logic [3:0] len;
    logic [63:0] m;
    logic [31:0] el;
    cmst_pkg::res_item_t r;
    n = 0;
    len = (it.dlc > cmst_pkg::FULL_LEN) ? cmst_pkg::FULL_LEN : it.dlc;
    fresh.delete();
    case (it.req_type)
      cmst_pkg::REQ_TICK: begin
        now_ms = now_ms + 32'd1;
        for (int i = 0; i < NSLOT; i++) begin
          if (slots[i].mode == cmst_pkg::MODE_TX) begin
            if (now_ms - slots[i].last_set >= {16'd0, slots[i].period} + {16'd0, m_margin})
              slots[i].mode = cmst_pkg::MODE_IDLE;
            else if (now_ms - slots[i].last_event >= {16'd0, slots[i].period} &&
                     n < cmst_pkg::MAX_RES) begin
              fresh.push_back(slot_view(cmst_pkg::KIND_TX, i, 1'b0));
              slots[i].last_event = now_ms;
              n++;
            end
          end
        end
        if (now_ms - age_stamp > {16'd0, m_interval}) begin
          for (int i = 0; i < NSLOT; i++)
            if (slots[i].mode == cmst_pkg::MODE_RX) begin
              slots[i].change_ages = age_up(slots[i].change_ages, slots[i].length);
              slots[i].recv_ages = age_up(slots[i].recv_ages, slots[i].length);
            end
          age_stamp = now_ms;
        end
        if (n > 0) begin
          r = fresh.pop_back();
          r.last = 1'b1;
          fresh.push_back(r);
        end
      end
      cmst_pkg::REQ_SET: begin
        for (int k = 0; k < 8; k++) m[k*8 +: 8] = (k < len) ? 8'hFF : 8'h00;
        s = slot_of(it.frame_id);
        slots[s].ident = it.frame_id;
        slots[s].ident_ok = 1'b1;
        slots[s].length = len;
        slots[s].period = it.cycle_ms;
        slots[s].bytes = (slots[s].bytes & ~m) | (it.payload & m);
        slots[s].mode = it.transmit_enable ? cmst_pkg::MODE_TX : cmst_pkg::MODE_IDLE;
        slots[s].last_set = now_ms;
      end
      cmst_pkg::REQ_RECV: begin
        if (!it.is_extended && !it.is_remote) begin
          s = slot_of(it.frame_id);
          slots[s].length = len;
          el = now_ms - slots[s].last_event;
          slots[s].period = (el > 32'd65535) ? 16'hFFFF : el[15:0];
          slots[s].last_event = now_ms;
          slots[s].mode = cmst_pkg::MODE_RX;
          for (int k = 0; k < 8; k++)
            if (k < len) begin
              if (slots[s].bytes[k*8 +: 8] != it.payload[k*8 +: 8])
                slots[s].change_ages[k*4 +: 4] = 4'd0;
              slots[s].bytes[k*8 +: 8] = it.payload[k*8 +: 8];
              slots[s].recv_ages[k*4 +: 4] = 4'd0;
            end
        end
      end
      default: begin
        s = it.slot_index;
        r = slot_view(cmst_pkg::KIND_READ, s, 1'b1);
        r.last = 1'b1;
        fresh.push_back(r);
        if (slots[s].mode == cmst_pkg::MODE_RX) slots[s].mode = cmst_pkg::MODE_IDLE;
      end
    endcase
  endtask

  // Offer one command and wait for its transfer; the model sees it at that edge.
  task automatic issue(input cmst_pkg::in_item_t it, input logic typed,
                       input cmst_pkg::res_item_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_data = it;
    @(posedge clk);
    while (busy) @(posedge clk);
    table_step(it);
    if (typed) pending_frames.push_back(want);
    else foreach (fresh[i]) pending_frames.push_back(fresh[i]);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    start = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cmst_pkg::CFG_AGE_INTERVAL: m_interval = val;
      cmst_pkg::CFG_AGE_LIMIT:    m_limit = val[3:0];
      default:                    m_margin = val;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Let every expected result come out, then give the engine time to finish.
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic cmst_pkg::in_item_t random_cmd();
    cmst_pkg::in_item_t it;
    int roll;
    roll = $urandom_range(0, 99);
    it.req_type = (roll < 45) ? cmst_pkg::REQ_TICK :
                  (roll < 65) ? cmst_pkg::REQ_SET :
                  (roll < 85) ? cmst_pkg::REQ_RECV : cmst_pkg::REQ_READ;
    // Half the time a pool of forty identifiers, so the table fills and the last slot is shared.
    it.frame_id = ($urandom_range(0, 1) == 0) ? 11'($urandom_range(0, 39) * 51)
                                              : 11'($urandom);
    it.is_extended = ($urandom_range(0, 9) == 0);
    it.is_remote = ($urandom_range(0, 9) == 0);
    it.dlc = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
    it.payload = {$urandom, $urandom};
    it.cycle_ms = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    it.transmit_enable = ($urandom_range(0, 6) != 0);
    it.slot_index = 5'($urandom);
    return it;
  endfunction

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    cmst_pkg::res_item_t w;
    if (rst_n && out_valid) begin
      if (pending_frames.size() == 0) begin
        $error("result with no expectation: %p", out_data);
        errors++;
      end else begin
        w = pending_frames.pop_front();
        if (out_data.result_kind !== w.result_kind) begin
          $error("result_kind exp %0h got %0h", w.result_kind, out_data.result_kind);
          errors++;
        end
        if (out_data.out_id !== w.out_id) begin
          $error("out_id exp %0h got %0h", w.out_id, out_data.out_id);
          errors++;
        end
        if (out_data.out_id_valid !== w.out_id_valid) begin
          $error("out_id_valid exp %0h got %0h", w.out_id_valid, out_data.out_id_valid);
          errors++;
        end
        if (out_data.out_dlc !== w.out_dlc) begin
          $error("out_dlc exp %0h got %0h", w.out_dlc, out_data.out_dlc);
          errors++;
        end
        if (out_data.out_payload !== w.out_payload) begin
          $error("out_payload exp %0h got %0h", w.out_payload, out_data.out_payload);
          errors++;
        end
        if (out_data.out_cycle_ms !== w.out_cycle_ms) begin
          $error("out_cycle_ms exp %0h got %0h", w.out_cycle_ms, out_data.out_cycle_ms);
          errors++;
        end
        if (out_data.out_mode !== w.out_mode) begin
          $error("out_mode exp %0h got %0h", w.out_mode, out_data.out_mode);
          errors++;
        end
        if (out_data.change_ages !== w.change_ages) begin
          $error("change_ages exp %0h got %0h", w.change_ages, out_data.change_ages);
          errors++;
        end
        if (out_data.recv_ages !== w.recv_ages) begin
          $error("recv_ages exp %0h got %0h", w.recv_ages, out_data.recv_ages);
          errors++;
        end
        if (out_data.last !== w.last) begin
          $error("last exp %0h got %0h", w.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles in which no transfer of any kind happens.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("FAIL can_message_slot_table_core");
      $finish;
    end
  end

  // Directed table: command, whether the expectation is typed in, and that expectation.
  typedef struct {
    cmst_pkg::in_item_t  cmd;
    logic                typed;
    cmst_pkg::res_item_t want;
  } row_t;

  function automatic cmst_pkg::in_item_t cmd_of(input logic [1:0] req, input logic [10:0] fid,
                                      input logic ext, input logic rem, input logic [3:0] dlc,
                                      input logic [63:0] pl, input logic [15:0] cyc,
                                      input logic en, input logic [4:0] idx);
    cmst_pkg::in_item_t it;
    it.req_type = req;
    it.frame_id = fid;
    it.is_extended = ext;
    it.is_remote = rem;
    it.dlc = dlc;
    it.payload = pl;
    it.cycle_ms = cyc;
    it.transmit_enable = en;
    it.slot_index = idx;
    return it;
  endfunction

  function automatic cmst_pkg::res_item_t read_of(input logic [10:0] id, input logic ok,
                                        input logic [3:0] dlc, input logic [63:0] pl,
                                        input logic [15:0] cyc, input logic [1:0] mode);
    cmst_pkg::res_item_t r;
    r = '0;
    r.result_kind = cmst_pkg::KIND_READ;
    r.out_id = id;
    r.out_id_valid = ok;
    r.out_dlc = dlc;
    r.out_payload = pl;
    r.out_cycle_ms = cyc;
    r.out_mode = mode;
    r.last = 1'b1;
    return r;
  endfunction

  row_t plan[$];
  logic [15:0] phase_cfg [4][3];

  initial begin
    row_t row;
    cmst_pkg::res_item_t unused;
    cmst_pkg::res_item_t fresh_slot;
    unused = '0;
    fresh_slot = read_of(11'd0, 1'b0, 4'd1, 64'd0, 16'd1500, cmst_pkg::MODE_IDLE);
    errors = 0;
    quiet_cycles = 0;
    sender_idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = cmst_pkg::CFG_AGE_INTERVAL;
    cfg_data = '0;
    model_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset contents, saturated length, ignored frames, both identifier extremes.
    plan.push_back('{cmd_of(cmst_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 5'd5), 1'b1, fresh_slot});
    plan.push_back('{cmd_of(cmst_pkg::REQ_SET, 11'h7FF, 0, 0, 4'hF, '1, 0, 1, 0), 1'b0,
                     unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 5'd0), 1'b1,
                     read_of(11'h7FF, 1'b1, 4'd8, '1, 16'd0, cmst_pkg::MODE_TX)});
    plan.push_back('{cmd_of(cmst_pkg::REQ_RECV, 11'd5, 1, 0, 8, '1, 0, 0, 0), 1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_RECV, 11'd6, 0, 1, 8, '1, 0, 0, 0), 1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 5'd1), 1'b1, fresh_slot});
    plan.push_back('{cmd_of(cmst_pkg::REQ_RECV, 11'd0, 0, 0, 8, 64'h0123456789ABCDEF,
                            0, 0, 0), 1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_RECV, 11'd0, 0, 0, 4'hC, 64'h0123456789ABCD00,
                            0, 0, 0), 1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 5'd1), 1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_RECV, 11'd0, 0, 0, 0, 0, 0, 0, 0), 1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_SET, 11'd0, 0, 0, 4, 64'hFFFF_FFFF, 16'hFFFF,
                            0, 0), 1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 5'd1), 1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_SET, 11'd100, 0, 0, 2, 64'hA5A5, 16'd3, 1, 0),
                     1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, unused});
    plan.push_back('{cmd_of(cmst_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 5'd31), 1'b1,
                     fresh_slot});
    foreach (plan[i]) issue(plan[i].cmd, plan[i].typed, plan[i].want);
    settle();

    // Register settings per random phase, extremes among them.
    phase_cfg = '{'{16'd1, 16'd15, 16'd5}, '{16'hFFFF, 16'd0, 16'd0},
                  '{16'd2, 16'd3, 16'hFFFF}, '{16'd3, 16'd15, 16'd10}};
    for (int p = 0; p < 4; p++) begin
      write_reg(cmst_pkg::CFG_AGE_INTERVAL, phase_cfg[p][0]);
      write_reg(cmst_pkg::CFG_AGE_LIMIT, phase_cfg[p][1]);
      write_reg(cmst_pkg::CFG_STALE_MARGIN, phase_cfg[p][2]);
      // Sender idling per phase: none, heavy, none, light.
      sender_idle_pct = (p == 1) ? 46 : (p == 3) ? 11 : 0;
      repeat (75) issue(random_cmd(), 1'b0, unused);
      settle();
    end

    if (pending_frames.size() != 0) begin
      $error("%0d expected results never arrived", pending_frames.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS can_message_slot_table_core");
    end else begin
      $display("FAIL can_message_slot_table_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cmst_pkg.sv
src/cmst_ram.sv
src/cmst_front.sv
src/cmst_queue.sv
src/cmst_back.sv
src/can_message_slot_table_core.sv
test/tb_can_message_slot_table_core.sv
